// ===== design/spq_pkg.sv =====
// spq_pkg: shared types, codes and defaults for the sorted priority queue
// no dependencies; imported by every module of the block
`default_nettype none

package spq_pkg;

    localparam int CAPACITY_DEF      = 16;
    localparam int PRIORITY_BITS_DEF = 8;
    localparam int VALUE_W           = 32;
    localparam int FIELD_PRIO_W      = 8;
    localparam int OCC_W             = 5;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_PEEK   = 2'd2
    } spq_func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } spq_status_t;

    typedef struct packed {
        logic [1:0]                     func;
        logic signed [VALUE_W-1:0]      item_value;
        logic [FIELD_PRIO_W-1:0]        item_priority;
    } spq_cmd_t;

    typedef struct packed {
        logic [1:0]                     status;
        logic signed [VALUE_W-1:0]      front_value;
        logic signed [VALUE_W-1:0]      rear_value;
        logic [OCC_W-1:0]               occupancy;
    } spq_result_t;

    // per-cycle command to the row of cells
    typedef struct packed {
        logic ins;
        logic pop;
    } spq_cell_ctl_t;

endpackage : spq_pkg

`default_nettype wire

// ===== design/spq_cell.sv =====
// spq_cell: one slot of the sorted list, holds a value and its priority
// depends on spq_pkg; instantiated in a row by sorted_priority_queue
`default_nettype none

module spq_cell #(
    parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
    input  wire                                   clk,
    input  spq_pkg::spq_cell_ctl_t                ctl,
    input  wire                                   occupied,
    input  wire logic signed [spq_pkg::VALUE_W-1:0] new_value,
    input  wire logic [PRIORITY_BITS-1:0]         new_prio,
    input  wire                                   left_ge,
    input  wire logic signed [spq_pkg::VALUE_W-1:0] left_value,
    input  wire logic [PRIORITY_BITS-1:0]         left_prio,
    input  wire logic signed [spq_pkg::VALUE_W-1:0] right_value,
    input  wire logic [PRIORITY_BITS-1:0]         right_prio,
    output logic signed [spq_pkg::VALUE_W-1:0]    value,
    output logic [PRIORITY_BITS-1:0]              prio,
    output logic                                  ge
);
    import spq_pkg::*;

    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic [PRIORITY_BITS-1:0]  prio_reg, prio_next;

    // held entry stays ahead of the new word on equal or higher priority
    assign ge    = occupied && (prio_reg >= new_prio);
    assign value = value_reg;
    assign prio  = prio_reg;

    always_comb
    begin
        value_next = value_reg;
        prio_next  = prio_reg;
        if (ctl.ins && !ge)
        begin
            if (left_ge)
            begin
                value_next = new_value;
                prio_next  = new_prio;
            end
            else
            begin
                value_next = left_value;
                prio_next  = left_prio;
            end
        end
        else if (ctl.pop)
        begin
            value_next = right_value;
            prio_next  = right_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

endmodule : spq_cell

`default_nettype wire

// ===== design/sorted_priority_queue.sv =====
// sorted_priority_queue: top level, command latch, fill count and row of cells
// depends on spq_pkg and spq_cell
`default_nettype none

// Bounded priority queue kept as a sorted row of CAPACITY cells, front in cell 0.
// A command is taken when start is high and busy is low; busy then stays high for
// one cycle while every cell compares its priority with the new word and shifts in
// the same clock, and done pulses on the following cycle with the result beat
// (status, front, rear, occupancy after the operation). One command therefore
// passes through the command latch and the single shift step of the cell row;
// a new command may be given in the cycle that done is high. The result is shown
// for that one cycle only and cannot be held off. Equal priorities leave
// in arrival order. Front and rear read zero when the queue is empty.
module sorted_priority_queue #(
    parameter int CAPACITY      = spq_pkg::CAPACITY_DEF,
    parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   start,
    input  spq_pkg::spq_cmd_t     cmd,
    output logic                  busy,
    output logic                  done,
    output spq_pkg::spq_result_t  result
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                      busy_reg;
    logic                      done_reg;
    spq_cmd_t                  cmd_reg;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic signed [VALUE_W-1:0] rear_reg, rear_next;
    logic [1:0]                status_reg, status_next;

    logic                      accept;
    logic [PRIORITY_BITS-1:0]  new_prio;
    logic                      full, empty, at_rear;
    spq_cell_ctl_t             ctl;

    logic signed [VALUE_W-1:0] cell_value [CAPACITY];
    logic [PRIORITY_BITS-1:0]  cell_prio  [CAPACITY];
    logic [CAPACITY-1:0]       cell_ge;
    logic [CAPACITY-1:0]       cell_occ;

    assign accept   = start && !busy_reg;
    assign new_prio = PRIORITY_BITS'(cmd_reg.item_priority);
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);
    // new word lands at the rear when no held entry ranks below it
    assign at_rear  = ~|(cell_occ & ~cell_ge);

    always_comb
    begin
        ctl         = '0;
        count_next  = count_reg;
        rear_next   = rear_reg;
        status_next = empty ? ST_EMPTY : ST_OK;
        unique case (cmd_reg.func)
            FUNC_INSERT:
            begin
                if (full)
                    status_next = ST_FULL;
                else
                begin
                    status_next = ST_OK;
                    ctl.ins     = busy_reg;
                    count_next  = count_reg + CNT_W'(1);
                    if (at_rear)
                        rear_next = cmd_reg.item_value;
                end
            end
            FUNC_POP:
            begin
                if (!empty)
                begin
                    ctl.pop    = busy_reg;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                // peek, and the unused code behaves as peek
                status_next = empty ? ST_EMPTY : ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg <= accept;
            done_reg <= busy_reg;
            if (busy_reg)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= cmd;
        if (busy_reg)
        begin
            rear_reg   <= rear_next;
            status_reg <= status_next;
        end
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                      l_ge;
            logic signed [VALUE_W-1:0] l_value, r_value;
            logic [PRIORITY_BITS-1:0]  l_prio, r_prio;

            assign cell_occ[i] = (CNT_W'(i) < count_reg);

            if (i == 0)
            begin : g_head
                assign l_ge    = 1'b1;
                assign l_value = cmd_reg.item_value;
                assign l_prio  = new_prio;
            end
            else
            begin : g_body
                assign l_ge    = cell_ge[i-1];
                assign l_value = cell_value[i-1];
                assign l_prio  = cell_prio[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign r_value = cell_value[i];
                assign r_prio  = cell_prio[i];
            end
            else
            begin : g_inner
                assign r_value = cell_value[i+1];
                assign r_prio  = cell_prio[i+1];
            end

            spq_cell #(
                .PRIORITY_BITS (PRIORITY_BITS)
            ) u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .occupied    (cell_occ[i]),
                .new_value   (cmd_reg.item_value),
                .new_prio    (new_prio),
                .left_ge     (l_ge),
                .left_value  (l_value),
                .left_prio   (l_prio),
                .right_value (r_value),
                .right_prio  (r_prio),
                .value       (cell_value[i]),
                .prio        (cell_prio[i]),
                .ge          (cell_ge[i])
            );
        end
    endgenerate

    // cells and count already hold the post-operation state during done
    always_comb
    begin
        result.status      = status_reg;
        result.front_value = empty ? '0 : cell_value[0];
        result.rear_value  = empty ? '0 : rear_reg;
        result.occupancy   = OCC_W'(count_reg);
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule : sorted_priority_queue

`default_nettype wire

// ===== design/spq_checker.sv =====
// spq_checker: port-level checks of the command and result beats
// depends on spq_pkg; bound to sorted_priority_queue at the end of this file
`default_nettype none

module spq_checker (
    input wire                   clk,
    input wire                   rst_n,
    input wire                   start,
    input wire                   busy,
    input wire                   done,
    input spq_pkg::spq_result_t  result
);
    import spq_pkg::*;

    // an accepted command blocks the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after command beat");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("result beat missing after busy cycle");

    a_done_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without a command");

    a_empty_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.occupancy == '0)
            |-> (result.front_value == '0 && result.rear_value == '0))
        else $error("empty queue reports nonzero data");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_EMPTY) |-> (result.occupancy == '0))
        else $error("empty status with entries held");

endmodule : spq_checker

bind sorted_priority_queue spq_checker u_spq_checker (.*);

`default_nettype wire
